// ===== hdl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, register map and control structs of the LRU page
// replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 32;
    localparam int CFG_W    = 4;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int ADDR_LSB = 2;
    localparam int INDEX_W  = ADDR_W - ADDR_LSB;

    localparam logic [CFG_W-1:0]   FRAMES_RESET      = 4'd8;
    localparam logic [INDEX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

    typedef struct packed {
        logic [CFG_W-1:0] frames_in_use;
        logic             flush;
    } cfg_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [COUNT_W-1:0] fault_count;
        logic               end_of_string;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/lrupr_cfg.sv =====
// ----------------------------------------------------------------------------
// lrupr_cfg
// APB register file: holds the frame count and pulses a flush on every write
// to it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrupr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lrupr_pkg::DATA_W-1:0]  pwdata,
    output      logic [lrupr_pkg::DATA_W-1:0]  prdata,
    output      logic                          pready,
    output      lrupr_pkg::cfg_t               cfg
);

    logic [lrupr_pkg::CFG_W-1:0]   frames_reg;
    logic [lrupr_pkg::CFG_W-1:0]   frames_next;
    logic                          flush_reg;
    logic                          flush_next;
    logic [lrupr_pkg::INDEX_W-1:0] reg_index;
    logic                          wr_frames;

    assign reg_index = paddr[lrupr_pkg::ADDR_W-1:lrupr_pkg::ADDR_LSB];
    assign wr_frames = psel && penable && pwrite
                       && (reg_index == lrupr_pkg::REG_FRAMES_IN_USE);

    always_comb
    begin
        frames_next = frames_reg;
        flush_next  = 1'b0;
        if (wr_frames)
        begin
            frames_next = pwdata[lrupr_pkg::CFG_W-1:0];
            flush_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= lrupr_pkg::FRAMES_RESET;
            flush_reg  <= 1'b0;
        end
        else
        begin
            frames_reg <= frames_next;
            flush_reg  <= flush_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == lrupr_pkg::REG_FRAMES_IN_USE)
        begin
            prdata = lrupr_pkg::DATA_W'(frames_reg);
        end
    end

    assign pready            = 1'b1;
    assign cfg.frames_in_use = frames_reg;
    assign cfg.flush         = flush_reg;

endmodule

`default_nettype wire

// ===== hdl/lrupr_core.sv =====
// ----------------------------------------------------------------------------
// lrupr_core
// Frame table with per-frame age ranks: parallel page compare, victim pick
// and rank update for one reference per cycle while process is high, plus resident and fault
// counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_core #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  process,
    input  wire logic [PAGE_BITS-1:0]  page,
    input  wire logic                  last,
    input  wire lrupr_pkg::cfg_t       cfg,
    output      lrupr_pkg::status_t    status,
    output      logic [PAGE_BITS-1:0]  evicted_page
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int LIM_W  = (FILL_W > lrupr_pkg::CFG_W) ? FILL_W : lrupr_pkg::CFG_W;
    localparam int COUNT_W = lrupr_pkg::COUNT_W;
    localparam int SLOT_W  = lrupr_pkg::SLOT_W;

    logic [PAGE_BITS-1:0]    page_reg [FRAMES];
    logic [RANK_W-1:0]       rank_reg [FRAMES];
    logic [RANK_W-1:0]       rank_next [FRAMES];
    logic [FILL_W-1:0]       filled_reg;
    logic [FILL_W-1:0]       filled_next;
    logic [COUNT_W-1:0]      fault_reg;
    logic [COUNT_W-1:0]      fault_next;
    logic [COUNT_W-1:0]      fault_inc;

    logic [LIM_W-1:0]        lim_ext;
    logic [FILL_W-1:0]       limit;
    logic [FRAMES-1:0]       resident;
    logic [FRAMES-1:0]       match;
    logic [FRAMES-1:0]       oldest;
    logic                    hit_w;
    logic                    full;
    logic                    evict;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        victim_idx;
    logic [IDX_W-1:0]        slot_idx;
    logic [RANK_W-1:0]       hit_rank;
    logic [RANK_W-1:0]       last_rank;
    logic [SLOT_W+IDX_W-1:0] slot_wide;

    // Clamp the configured frame count into 1..FRAMES
    always_comb
    begin
        lim_ext = LIM_W'(cfg.frames_in_use);
        priority if (lim_ext == '0)
        begin
            limit = FILL_W'(1);
        end
        else if (lim_ext > LIM_W'(FRAMES))
        begin
            limit = FILL_W'(FRAMES);
        end
        else
        begin
            limit = FILL_W'(lim_ext);
        end
    end

    assign last_rank = RANK_W'(filled_reg - FILL_W'(1));

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            resident[i] = FILL_W'(i) < filled_reg;
            match[i]    = resident[i] && (page_reg[i] == page);
            // ranks are dense, so the least recent frame holds the top rank
            oldest[i]   = resident[i] && (rank_reg[i] == last_rank);
        end
    end

    // Lowest matching and oldest frame
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (oldest[i])
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    assign hit_w    = |match;
    assign full     = filled_reg >= limit;
    assign evict    = !hit_w && full;
    assign hit_rank = rank_reg[hit_idx];

    always_comb
    begin
        priority if (hit_w)
        begin
            slot_idx = hit_idx;
        end
        else if (full)
        begin
            slot_idx = victim_idx;
        end
        else
        begin
            slot_idx = IDX_W'(filled_reg);
        end
    end

    // Age every other resident frame that the referenced one passes
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (IDX_W'(i) == slot_idx)
            begin
                rank_next[i] = '0;
            end
            else if (resident[i] && (!hit_w || (rank_reg[i] < hit_rank)))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
    end

    assign fault_inc = (fault_reg == '1) ? fault_reg : fault_reg + COUNT_W'(1);

    always_comb
    begin
        fault_next  = hit_w ? fault_reg : fault_inc;
        filled_next = (!hit_w && !full) ? filled_reg + FILL_W'(1) : filled_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (!hit_w)
            begin
                page_reg[slot_idx] <= page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            fault_reg  <= '0;
        end
        else if (cfg.flush || (process && last))
        begin
            filled_reg <= '0;
            fault_reg  <= '0;
        end
        else if (process)
        begin
            filled_reg <= filled_next;
            fault_reg  <= fault_next;
        end
    end

    assign slot_wide = {SLOT_W'(0), slot_idx};

    assign status.hit           = hit_w;
    assign status.slot          = slot_wide[SLOT_W-1:0];
    assign status.evicted_valid = evict;
    assign status.fault_count   = fault_next;
    assign status.end_of_string = last;
    assign evicted_page         = evict ? page_reg[victim_idx] : '0;

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement: one result per page reference.
//
// Usage:
//   The reference channel (ref_valid / ref_stall) carries page_number and
//   last_reference. The result channel (res_valid / res_stall) carries hit,
//   slot, evicted_valid, evicted_page, fault_count and end_of_string.
//   A transfer completes at a clock edge with valid high and stall low.
//   A reference passes through the input register and then the result
//   register, where res_valid rises; one reference is taken every cycle
//   while ref_stall is low, as the compare and rank update between the
//   input register and the result register are combinational.
//   A reference with last_reference set gets its result normally, then all
//   frames empty and the fault count returns to zero.
//   Reset empties all frames, clears the fault count and sets
//   frames_in_use to 8. Writing frames_in_use over APB (address 0) also
//   empties the frames; write it only while the block is idle.
//   While res_stall is high the result holds; one more reference is taken
//   into the input register, then ref_stall rises until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lrupr_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [lrupr_pkg::DATA_W-1:0]        pwdata,
    output      logic [lrupr_pkg::DATA_W-1:0]        prdata,
    output      logic                                pready,

    input  wire logic                                ref_valid,
    output      logic                                ref_stall,
    input  wire logic [PAGE_BITS-1:0]                page_number,
    input  wire logic                                last_reference,

    output      logic                                res_valid,
    input  wire logic                                res_stall,
    output      logic                                hit,
    output      logic [lrupr_pkg::SLOT_W-1:0]        slot,
    output      logic                                evicted_valid,
    output      logic [PAGE_BITS-1:0]                evicted_page,
    output      logic [lrupr_pkg::COUNT_W-1:0]       fault_count,
    output      logic                                end_of_string
);

    lrupr_pkg::cfg_t    cfg;
    lrupr_pkg::status_t status;
    lrupr_pkg::status_t status_reg;
    logic [PAGE_BITS-1:0] evicted_w;
    logic [PAGE_BITS-1:0] evicted_reg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [PAGE_BITS-1:0] in_page_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 process;
    logic                 take;

    lrupr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrupr_core #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .process      (process),
        .page         (in_page_reg),
        .last         (in_last_reg),
        .cfg          (cfg),
        .status       (status),
        .evicted_page (evicted_w)
    );

    // Advance the held reference whenever the result register is free
    assign process   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign ref_stall = in_valid_reg && !process;
    assign take      = ref_valid && !ref_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_page_reg <= page_number;
            in_last_reg <= last_reference;
        end
        if (process)
        begin
            status_reg  <= status;
            evicted_reg <= evicted_w;
        end
    end

    assign res_valid     = out_valid_reg;
    assign hit           = status_reg.hit;
    assign slot          = status_reg.slot;
    assign evicted_valid = status_reg.evicted_valid;
    assign evicted_page  = evicted_reg;
    assign fault_count   = status_reg.fault_count;
    assign end_of_string = status_reg.end_of_string;

endmodule

`default_nettype wire
